FILE: hdl/tctt_pkg.sv
// Shared types, voltage table and reciprocal lookup for the thermistor code converter.
package tctt_pkg;

  localparam int STORED_POINTS    = 33;
  localparam int TABLE_POINTS_DEF = 33;
  localparam int SEG_SPAN_CENTI   = 500;
  localparam int RECIP_SHIFT      = 20;

  localparam logic signed [14:0] TEMP_MIN_CENTI = -15'sd4000;

  // Voltage points in 50 uV units relative to 1.5 V, falling from -40 C to 120 C in 5 C steps.
  localparam logic signed [17:0] VOLT_PTS [0:STORED_POINTS-1] = '{
    18'sd18800, 18'sd18400, 18'sd18000, 18'sd17600, 18'sd17000, 18'sd16400,
    18'sd15400, 18'sd14600, 18'sd13400, 18'sd12200, 18'sd11000, 18'sd9800,
    18'sd8400,  18'sd7200,  18'sd6000,  18'sd4800,  18'sd3600,  18'sd2600,
    18'sd1800,  18'sd1000,  18'sd200,   -18'sd400,  -18'sd1000, -18'sd1400,
    -18'sd2000, -18'sd2400, -18'sd2600, -18'sd3000, -18'sd3200, -18'sd3400,
    -18'sd3600, -18'sd3800, -18'sd4000
  };

  // Segment width divided by 100. The last entry belongs to the hot end, where the
  // distance is always zero, so its value never affects a result.
  localparam logic [3:0] SEG_DIV [0:STORED_POINTS-1] = '{
    4'd4,  4'd4,  4'd4,  4'd6,  4'd6,  4'd10, 4'd8,  4'd12, 4'd12, 4'd12, 4'd12,
    4'd14, 4'd12, 4'd12, 4'd12, 4'd12, 4'd10, 4'd8,  4'd8,  4'd8,  4'd6,  4'd6,
    4'd4,  4'd6,  4'd4,  4'd2,  4'd4,  4'd2,  4'd2,  4'd2,  4'd2,  4'd2,  4'd2
  };

  // Result of the segment search, handed from the locator to the interpolator.
  typedef struct packed {
    logic signed [14:0] t1;      // temperature at the segment's upper voltage point
    logic [10:0]        offset;  // upper point minus scaled code, zero when clamped
    logic [3:0]         div;     // segment width divided by 100
    logic               cold;
    logic               hot;
  } loc_t;

  // floor(2^RECIP_SHIFT / div) for each segment width that occurs in the table.
  function automatic logic [19:0] recip_of(input logic [3:0] div);
    logic [19:0] r;
    unique case (div)
      4'd2:    r = 20'd524288;
      4'd4:    r = 20'd262144;
      4'd6:    r = 20'd174762;
      4'd8:    r = 20'd131072;
      4'd10:   r = 20'd104857;
      4'd12:   r = 20'd87381;
      4'd14:   r = 20'd74898;
      default: r = 20'd524288;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/tctt_locate.sv
// Front half of the pipeline: scale the code, compare against the table, pick the segment.
module tctt_locate #(
  parameter int TABLE_POINTS = tctt_pkg::TABLE_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  in_code,
  output logic                out_valid,
  input  logic                out_ready,
  output tctt_pkg::loc_t      out_loc
);

  localparam int NPTS  = (TABLE_POINTS < 2) ? 2 :
                         (TABLE_POINTS > tctt_pkg::STORED_POINTS) ?
                         tctt_pkg::STORED_POINTS : TABLE_POINTS;
  localparam int SEG_W = $clog2(NPTS);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [17:0] x1_r, x2_r, x3_r;
  logic signed [17:0] x1_nxt;
  logic [NPTS-1:0]    gt2_r, gt2_nxt;
  logic [SEG_W-1:0]   seg3_r, seg3_nxt, seg_enc;
  logic               cold3_r, hot3_r, cold3_nxt, hot3_nxt;
  tctt_pkg::loc_t     loc4_r, loc4_nxt;

  logic signed [17:0] code_ext;
  logic signed [17:0] diff;
  logic [14:0]        step;

  // A stage takes a new beat when it is empty or its successor is taking its beat.
  assign rdy4     = !v4_r || out_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    code_ext = 18'(in_code);
    x1_nxt   = code_ext + (code_ext <<< 1);
  end

  // The last point counts as above x when x sits exactly on it, so that code clamps hot.
  always_comb begin
    for (int j = 0; j < NPTS - 1; j++) begin
      gt2_nxt[j] = tctt_pkg::VOLT_PTS[j] > x1_r;
    end
    gt2_nxt[NPTS-1] = tctt_pkg::VOLT_PTS[NPTS-1] >= x1_r;
  end

  // The points above x form a run from index zero; the segment sits at the end of that run.
  always_comb begin
    seg_enc = '0;
    for (int i = 0; i < NPTS - 1; i++) begin
      if (gt2_r[i] && !gt2_r[i+1]) begin
        seg_enc = seg_enc | SEG_W'(i);
      end
    end
    cold3_nxt = !gt2_r[0];
    hot3_nxt  = gt2_r[0] && gt2_r[NPTS-1];
    seg3_nxt  = hot3_nxt ? SEG_W'(NPTS - 1) : seg_enc;
  end

  always_comb begin
    diff            = tctt_pkg::VOLT_PTS[seg3_r] - x3_r;
    step            = 15'(seg3_r) * 15'(tctt_pkg::SEG_SPAN_CENTI);
    loc4_nxt.t1     = tctt_pkg::TEMP_MIN_CENTI + signed'(step);
    loc4_nxt.offset = (cold3_r || hot3_r) ? 11'd0 : diff[10:0];
    loc4_nxt.div    = tctt_pkg::SEG_DIV[seg3_r];
    loc4_nxt.cold   = cold3_r;
    loc4_nxt.hot    = hot3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      x1_r <= x1_nxt;
    end
    if (rdy2 && v1_r) begin
      x2_r  <= x1_r;
      gt2_r <= gt2_nxt;
    end
    if (rdy3 && v2_r) begin
      x3_r    <= x2_r;
      seg3_r  <= seg3_nxt;
      cold3_r <= cold3_nxt;
      hot3_r  <= hot3_nxt;
    end
    if (rdy4 && v3_r) begin
      loc4_r <= loc4_nxt;
    end
  end

  assign out_valid = v4_r;
  assign out_loc   = loc4_r;

endmodule

FILE: hdl/tctt_interp.sv
// Back half of the pipeline: divide the in-segment distance by reciprocal and add the base.
module tctt_interp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tctt_pkg::loc_t     in_loc,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] out_temp,
  output logic               out_cold,
  output logic               out_hot
);

  localparam int RS = tctt_pkg::RECIP_SHIFT;

  logic v5_r, v6_r, v7_r, v8_r;
  logic rdy5, rdy6, rdy7, rdy8;

  tctt_pkg::loc_t     meta5_r, meta6_r, meta7_r;
  logic [12:0]        n5_r, n6_r;
  logic [12:0]        n5_nxt;
  logic [19:0]        recip5_r;
  logic [32:0]        prod6_r, prod6_nxt;
  logic [8:0]         q7_r, q_est;
  logic [4:0]         rem7_r, rem7_nxt;
  logic [12:0]        back;
  logic [12:0]        rem_full;
  logic [9:0]         q_fix, frac;
  logic [4:0]         rem_fix;
  logic [4:0]         div_ext;
  logic signed [14:0] temp8_r, temp8_nxt;
  logic               cold8_r, hot8_r;

  assign rdy8     = !v8_r || out_ready;
  assign rdy7     = !v7_r || rdy8;
  assign rdy6     = !v6_r || rdy7;
  assign rdy5     = !v5_r || rdy6;
  assign in_ready = rdy5;

  // The fraction in 0.01 C is 500 * offset / (100 * div), that is 5 * offset / div.
  assign n5_nxt    = 13'({in_loc.offset, 2'b00}) + 13'(in_loc.offset);
  assign prod6_nxt = 33'(n5_r) * 33'(recip5_r);

  // The truncated reciprocal can come out one low, never high.
  always_comb begin
    q_est    = prod6_r[RS+8:RS];
    back     = 13'(q_est) * 13'(meta6_r.div);
    rem_full = n6_r - back;
    rem7_nxt = rem_full[4:0];
  end

  // Below 0 C the fraction rounds up so that the sum truncates toward zero.
  always_comb begin
    div_ext = 5'(meta7_r.div);
    if (rem7_r >= div_ext) begin
      q_fix   = 10'(q7_r) + 10'd1;
      rem_fix = rem7_r - div_ext;
    end else begin
      q_fix   = 10'(q7_r);
      rem_fix = rem7_r;
    end
    frac      = q_fix + 10'((meta7_r.t1 < 0) && (rem_fix != 5'd0));
    temp8_nxt = meta7_r.t1 + signed'(15'(frac));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      if (rdy5) v5_r <= in_valid;
      if (rdy6) v6_r <= v5_r;
      if (rdy7) v7_r <= v6_r;
      if (rdy8) v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5 && in_valid) begin
      meta5_r  <= in_loc;
      n5_r     <= n5_nxt;
      recip5_r <= tctt_pkg::recip_of(in_loc.div);
    end
    if (rdy6 && v5_r) begin
      meta6_r <= meta5_r;
      n6_r    <= n5_r;
      prod6_r <= prod6_nxt;
    end
    if (rdy7 && v6_r) begin
      meta7_r <= meta6_r;
      q7_r    <= q_est;
      rem7_r  <= rem7_nxt;
    end
    if (rdy8 && v7_r) begin
      temp8_r <= temp8_nxt;
      cold8_r <= meta7_r.cold;
      hot8_r  <= meta7_r.hot;
    end
  end

  assign out_valid = v8_r;
  assign out_temp  = temp8_r;
  assign out_cold  = cold8_r;
  assign out_hot   = hot8_r;

endmodule

FILE: hdl/thermistor_code_to_temperature.sv
// Top level: converts a signed converter code into an NTC thermistor temperature.
//
// Input stream: one beat per converter code, in_tdata[15:0] signed, 1.5 V plus 150 uV per count.
// Output stream: one beat per input beat, in order. out_tdata[14:0] is the temperature in
// 0.01 C, signed, -4000 to 12000. out_tuser[0] flags a cold clamp (voltage at or above the
// first table point, result -40 C), out_tuser[1] a hot clamp (at or below the last point in use).
// The block keeps no state between codes. It is an eight-stage pipeline: the scale, the
// 33-way compare, the segment encode, the table fetch, the times-five step, the reciprocal
// multiply, the remainder check and the final rounding add each own one register stage.
// The accepting edge loads the first stage and each later stage registers the beat in
// turn; one code per cycle is accepted in steady state while out_tready stays high.
// Reset clears all valid bits; nothing else needs clearing. When the receiver holds
// out_tready low, stages keep their beats and ready is formed combinationally back through
// the stages, so empty stages still fill; in_tready drops only once every stage holds a beat.
module thermistor_code_to_temperature #(
  parameter int TABLE_POINTS = tctt_pkg::TABLE_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] adc_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [14:0] temp_centi, [15] zero
  output logic [1:0]  out_tuser   // [0] clamped_cold, [1] clamped_hot
);

  logic               loc_valid;
  logic               loc_ready;
  tctt_pkg::loc_t     loc;
  logic signed [14:0] temp;
  logic               cold;
  logic               hot;

  tctt_locate #(
    .TABLE_POINTS (TABLE_POINTS)
  ) u_locate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_code   (signed'(in_tdata)),
    .out_valid (loc_valid),
    .out_ready (loc_ready),
    .out_loc   (loc)
  );

  tctt_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (loc_valid),
    .in_ready  (loc_ready),
    .in_loc    (loc),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_temp  (temp),
    .out_cold  (cold),
    .out_hot   (hot)
  );

  assign out_tdata = {1'b0, temp};
  assign out_tuser = {hot, cold};

`ifndef SYNTHESIS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("cold and hot clamp flags both set");

  a_cold_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (signed'(out_tdata[14:0]) == -15'sd4000))
    else $error("cold clamp without -40 C result");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (signed'(out_tdata[14:0]) >= -15'sd4000 &&
                    signed'(out_tdata[14:0]) <= 15'sd12000))
    else $error("temperature outside table range");

  a_loc_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (loc_valid && (loc.cold || loc.hot)) |-> (loc.offset == 11'd0))
    else $error("clamped beat carries a nonzero segment distance");
`endif

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the thermistor code to temperature converter.
`timescale 1ns / 100ps

module testbench;

  localparam int PTS_USED    = 33;
  localparam int CYCLE_LIMIT = 600000;
  localparam int N_RANDOM    = 1600;
  localparam int DRAIN_WAIT  = 16;

  // Voltage points in 50 uV steps relative to 1.5 V, one per 5 C from -40 C upward.
  localparam int POINT_VOLTS [0:32] = '{
    18800, 18400, 18000, 17600, 17000, 16400, 15400, 14600, 13400,
    12200, 11000,  9800,  8400,  7200,  6000,  4800,  3600,
     2600,  1800,  1000,   200,  -400, -1000, -1400, -2000,
    -2400, -2600, -3000, -3200, -3400, -3600, -3800, -4000
  };

  class temp_scoreboard;
    typedef struct {
      logic [15:0]        code;
      logic signed [14:0] temp;
      logic               cold;
      logic               hot;
    } reading_t;

    reading_t pending_readings[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    function automatic reading_t convert_code(logic [15:0] code);
      reading_t r;
      int x, n, seg, v1, v2, t1, num, den, frac, i;
      x = 3 * int'($signed(code));
      n = PTS_USED;
      if (n < 2) n = 2;
      if (n > 33) n = 33;
      r.code = code;
      r.cold = 1'b0;
      r.hot  = 1'b0;
      if (x >= POINT_VOLTS[0]) begin
        r.temp = -15'sd4000;
        r.cold = 1'b1;
      end else if (x <= POINT_VOLTS[n-1]) begin
        r.temp = 15'(-4000 + 500 * (n - 1));
        r.hot  = 1'b1;
      end else begin
        // Scan downward so that the first segment in table order wins on a shared point.
        seg = n - 2;
        for (i = n - 2; i >= 0; i--) begin
          if (x <= POINT_VOLTS[i] && x >= POINT_VOLTS[i+1]) seg = i;
        end
        v1  = POINT_VOLTS[seg];
        v2  = POINT_VOLTS[seg+1];
        t1  = -4000 + 500 * seg;
        num = 500 * (v1 - x);
        den = v1 - v2;
        // Truncation toward zero of the sum means rounding the fraction up below 0 C.
        if (t1 < 0) frac = (num + den - 1) / den;
        else        frac = num / den;
        r.temp = 15'(t1 + frac);
      end
      return r;
    endfunction

    function void note_code(logic [15:0] code);
      pending_readings.push_back(convert_code(code));
    endfunction

    function void check_beat(logic [15:0] tdata, logic [1:0] tuser);
      reading_t want;
      if (pending_readings.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result beat with nothing pending: tdata=%h tuser=%b", tdata, tuser);
        return;
      end
      want = pending_readings.pop_front();
      if (tdata[14:0] !== want.temp || tdata[15] !== 1'b0 ||
          tuser[0] !== want.cold || tuser[1] !== want.hot) begin
        errors++;
        if (errors <= 10)
          $display({"ERROR: code %0d: expected temp %0d cold %b hot %b, ",
                    "got temp %0d cold %b hot %b (bit15 %b)"},
                   $signed(want.code), want.temp, want.cold, want.hot,
                   $signed(tdata[14:0]), tuser[0], tuser[1], tdata[15]);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;

  temp_scoreboard sb = new();
  int             cycles;

  thermistor_code_to_temperature #(
    .TABLE_POINTS(PTS_USED)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Pacing modes: 0 no gaps, 1 gaps over the full range, 2 short gaps.
  function automatic int draw_wait(int mode);
    if (mode == 0) return 0;
    if (mode == 1) return $urandom_range(0, 19);
    return $urandom_range(0, 3);
  endfunction

  function automatic logic [15:0] draw_code();
    int pick;
    pick = $urandom_range(0, 99);
    // Most codes fall inside the table; some sit on the clamp edges, a few anywhere.
    if (pick < 80) return 16'($urandom_range(0, 7610) - 1340);
    if (pick < 85) return 16'($urandom_range(0, 20) + 6256);
    if (pick < 90) return 16'($urandom_range(0, 20) - 1344);
    return 16'($urandom);
  endfunction

  int send_mode;

  task automatic send_code(input logic [15:0] code);
    int gap;
    gap = draw_wait(send_mode);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    do @(posedge clk); while (!in_tready);
    sb.note_code(code);
  endtask

  // Result side: per beat, a random stall before ready is raised.
  initial begin
    int recv_mode, stall, beats;
    out_tready <= 1'b0;
    recv_mode = 1;
    beats = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (beats % 50 == 0) recv_mode = $urandom_range(0, 2);
      stall = draw_wait(recv_mode);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_beat(out_tdata, out_tuser);
      beats++;
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [15:0] directed_codes [$];
    int k;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 16'h0000;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Range ends, both clamp thresholds, codes landing exactly on table points,
    // the zero crossing and alternating bit patterns.
    directed_codes = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001,
                       16'(6267), 16'(6266), 16'(6268), 16'(6000), 16'(2800),
                       16'(1200), 16'(600), 16'(-1333), 16'(-1334), 16'(-1200),
                       16'(-1000), 16'(-800), 16'(-67), 16'h5555, 16'hAAAA,
                       16'(4000), 16'(-400)};
    send_mode = 1;
    foreach (directed_codes[k]) send_code(directed_codes[k]);

    for (k = 0; k < N_RANDOM; k++) begin
      if (k % 50 == 0) send_mode = $urandom_range(0, 2);
      send_code(draw_code());
    end
    in_tvalid <= 1'b0;

    while (sb.pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
